FILE: design/pst_pkg.sv
package pst_pkg;

  // scheduler dimensions
  localparam int unsigned NUM_PRIOS    = 32;
  localparam int unsigned TIMEOUT_BITS = 16;
  localparam int unsigned PRIO_W       = 6;
  localparam int unsigned TICKS_W      = 16;
  localparam int unsigned BITS_W       = 32;

  // largest value a timeout counter can hold
  localparam logic [32:0] TIMEOUT_MAX = (33'd1 << TIMEOUT_BITS) - 33'd1;

  // kernel event codes
  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_DELAY    = 2'd1,
    KIND_REGISTER = 2'd2,
    KIND_SCHEDULE = 2'd3
  } kind_e;

  // request transaction
  typedef struct packed {
    logic [1:0]         kind;
    logic [PRIO_W-1:0]  thread_prio;
    logic [TICKS_W-1:0] delay_ticks;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [PRIO_W-1:0] next_prio;
    logic              switch_request;
    logic              error_flag;
    logic [BITS_W-1:0] ready_bits;
    logic [BITS_W-1:0] delayed_bits;
  } res_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                    tick;
    logic                    delay_en;
    logic [PRIO_W-1:0]       delay_prio;
    logic [TIMEOUT_BITS-1:0] load;
    logic                    reg_en;
    logic [PRIO_W-1:0]       reg_prio;
  } cell_ctrl_t;

  // status returned by each cell
  typedef struct packed {
    logic ready_next;
    logic delayed_next;
    logic registered;
    logic sel;
  } cell_stat_t;

  // clamp a requested delay to the counter range
  function automatic logic [TIMEOUT_BITS-1:0] sat_ticks(input logic [TICKS_W-1:0] ticks);
    logic [32:0] t;
    t = 33'(ticks);
    if (t > TIMEOUT_MAX) begin
      t = TIMEOUT_MAX;
    end
    return TIMEOUT_BITS'(t);
  endfunction

endpackage

FILE: design/pst_cell.sv
module pst_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pst_pkg::cell_ctrl_t  ctrl_i,
  input  logic [5:0]           cell_prio_i,
  input  logic                 hp_i,
  output logic                 hp_o,
  output pst_pkg::cell_stat_t  stat_o
);
  import pst_pkg::*;

  logic                    ready_q, ready_d;
  logic                    delayed_q, delayed_d;
  logic                    registered_q, registered_d;
  logic [TIMEOUT_BITS-1:0] cnt_q, cnt_d;
  logic                    mine_delay, mine_reg;

  assign mine_delay = ctrl_i.delay_en && (ctrl_i.delay_prio == cell_prio_i);
  assign mine_reg   = ctrl_i.reg_en && (ctrl_i.reg_prio == cell_prio_i);

  // per-priority state update
  always_comb begin
    ready_d      = ready_q;
    delayed_d    = delayed_q;
    registered_d = registered_q;
    cnt_d        = cnt_q;
    if (ctrl_i.tick && delayed_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - TIMEOUT_BITS'(1);
      end
      if (cnt_q <= TIMEOUT_BITS'(1)) begin
        ready_d   = 1'b1;
        delayed_d = 1'b0;
      end
    end
    if (mine_delay) begin
      cnt_d     = ctrl_i.load;
      ready_d   = 1'b0;
      delayed_d = 1'b1;
    end
    if (mine_reg) begin
      registered_d = 1'b1;
      ready_d      = 1'b1;
    end
  end

  // priority chain: a higher cell that is ready blocks this one
  assign hp_o = hp_i | ready_d;

  assign stat_o.ready_next   = ready_d;
  assign stat_o.delayed_next = delayed_d;
  assign stat_o.registered   = registered_q;
  assign stat_o.sel          = ready_d & ~hp_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q      <= 1'b0;
      delayed_q    <= 1'b0;
      registered_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      ready_q      <= ready_d;
      delayed_q    <= delayed_d;
      registered_q <= registered_d;
      cnt_q        <= cnt_d;
    end
  end

endmodule

FILE: design/priority_thread_scheduler.sv
// channel   | ports                   | handshake
// ----------+-------------------------+------------------------------------------
// request   | start_i, busy_o, req_i  | taken at an edge with start_i high, busy_o low
// result    | done_o, result_o        | one-cycle strobe, taken at the edge ending it
//
// each result is registered and shows in the cycle after its request is accepted
// the pick ripples through the row of 32 priority cells in the accept cycle
// busy_o stays low, so a request can be taken in every cycle
// reset clears all sets, timeouts and the running thread at once
// the receiver cannot stall; results are never held back
module priority_thread_scheduler (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  pst_pkg::req_t   req_i,
  output logic            done_o,
  output pst_pkg::res_t   result_o
);
  import pst_pkg::*;

  cell_ctrl_t              ctrl;
  cell_stat_t              stat [NUM_PRIOS];
  logic [NUM_PRIOS:0]      hp;
  logic [NUM_PRIOS-1:0]    rdy_vec, dly_vec, reg_vec;
  logic [63:0]             reg_all;
  logic                    accept;
  logic                    is_tick, is_delay, is_reg, is_sched;
  logic                    delay_ok, reg_ok, sched, sw;
  logic [PRIO_W-1:0]       pick;
  logic                    idle_reg_q, idle_reg_d;
  logic [PRIO_W-1:0]       cur_prio_q, cur_prio_d;
  logic                    cur_valid_q, cur_valid_d;
  logic                    done_q;
  res_t                    res_q, res_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // decode the request
  assign is_tick  = req_i.kind == KIND_TICK;
  assign is_delay = req_i.kind == KIND_DELAY;
  assign is_reg   = req_i.kind == KIND_REGISTER;
  assign is_sched = req_i.kind == KIND_SCHEDULE;

  assign reg_all  = 64'({reg_vec, idle_reg_q});
  assign delay_ok = cur_valid_q && (cur_prio_q != '0) && (req_i.delay_ticks != '0);
  assign reg_ok   = (req_i.thread_prio <= PRIO_W'(NUM_PRIOS)) && !reg_all[req_i.thread_prio];
  assign sched    = accept && (is_sched || (is_delay && delay_ok));

  // command broadcast to the cells
  always_comb begin
    ctrl.tick       = accept && is_tick;
    ctrl.delay_en   = accept && is_delay && delay_ok;
    ctrl.delay_prio = cur_prio_q;
    ctrl.load       = sat_ticks(req_i.delay_ticks);
    ctrl.reg_en     = accept && is_reg && reg_ok;
    ctrl.reg_prio   = req_i.thread_prio;
  end

  // row of priority cells, highest priority at the head of the chain
  assign hp[NUM_PRIOS] = 1'b0;
  for (genvar g = 0; g < NUM_PRIOS; g++) begin : g_cell
    pst_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .cell_prio_i (PRIO_W'(g + 1)),
      .hp_i        (hp[g+1]),
      .hp_o        (hp[g]),
      .stat_o      (stat[g])
    );
    assign rdy_vec[g] = stat[g].ready_next;
    assign dly_vec[g] = stat[g].delayed_next;
    assign reg_vec[g] = stat[g].registered;
  end

  // one-hot select to priority number
  always_comb begin
    pick = '0;
    for (int i = 0; i < NUM_PRIOS; i++) begin
      if (stat[i].sel) begin
        pick = pick | PRIO_W'(i + 1);
      end
    end
  end

  assign sw = !cur_valid_q || (pick != cur_prio_q);

  // running thread and result
  always_comb begin
    cur_prio_d  = cur_prio_q;
    cur_valid_d = cur_valid_q;
    idle_reg_d  = idle_reg_q;
    if (sched) begin
      cur_prio_d  = pick;
      cur_valid_d = 1'b1;
    end
    if (ctrl.reg_en && (req_i.thread_prio == '0)) begin
      idle_reg_d = 1'b1;
    end
    res_d.next_prio      = sched ? pick : cur_prio_q;
    res_d.switch_request = sched && sw;
    res_d.error_flag     = accept && ((is_delay && !delay_ok) || (is_reg && !reg_ok));
    res_d.ready_bits     = BITS_W'(rdy_vec);
    res_d.delayed_bits   = BITS_W'(dly_vec);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_prio_q  <= '0;
      cur_valid_q <= 1'b0;
      idle_reg_q  <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      cur_prio_q  <= cur_prio_d;
      cur_valid_q <= cur_valid_d;
      idle_reg_q  <= idle_reg_d;
      done_q      <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // a thread is never ready and delayed at once
  assert property (@(posedge clk_i) disable iff (!rst_ni) (rdy_vec & dly_vec) == '0)
    else $error("thread both ready and delayed");

  // rejected transactions never request a switch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.error_flag) |-> !result_o.switch_request)
    else $error("switch on rejected transaction");

  // the reported thread is the running one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.next_prio == cur_prio_q))
    else $error("result disagrees with running thread");

  // the chain picks nothing exactly when no thread is ready
  assert property (@(posedge clk_i) disable iff (!rst_ni) (pick == '0) == !hp[0])
    else $error("priority chain and pick disagree");

endmodule

FILE: tb/testbench.sv
module testbench;
  import pst_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic done_o;
  res_t result_o;

  priority_thread_scheduler dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // scheduler state as the checker sees it
  logic [NUM_PRIOS-1:0]    sch_ready;
  logic [NUM_PRIOS-1:0]    sch_delayed;
  logic [NUM_PRIOS:0]      sch_registered;
  logic [TIMEOUT_BITS-1:0] sch_timeout [NUM_PRIOS];
  logic [PRIO_W-1:0]       sch_running;
  logic                    sch_running_valid;

  res_t expected_results [$];

  int unsigned n_events;
  int unsigned n_checked;
  int unsigned n_mismatches;
  int unsigned n_rejected;
  int unsigned n_switches;
  int unsigned n_cycles;

  // highest ready priority, idle when the ready set is empty
  function automatic logic [PRIO_W-1:0] highest_ready_prio();
    for (int p = NUM_PRIOS; p >= 1; p--) begin
      if (sch_ready[p-1]) begin
        return PRIO_W'(p);
      end
    end
    return '0;
  endfunction

  // pick the next thread; returns the switch request
  function automatic logic pick_next_thread();
    logic [PRIO_W-1:0] pick;
    logic sw;
    pick = highest_ready_prio();
    sw = !sch_running_valid || (pick != sch_running);
    sch_running = pick;
    sch_running_valid = 1'b1;
    return sw;
  endfunction

  // apply one kernel event to the scheduler state and form its result
  function automatic res_t sched_predict(input req_t r);
    res_t res;
    logic sw;
    logic err;
    logic [4:0] idx;
    logic [31:0] ticks;
    sw = 1'b0;
    err = 1'b0;
    case (kind_e'(r.kind))
      KIND_TICK: begin
        for (int p = 0; p < NUM_PRIOS; p++) begin
          if (sch_delayed[p]) begin
            if (sch_timeout[p] != '0) begin
              sch_timeout[p] = sch_timeout[p] - TIMEOUT_BITS'(1);
            end
            if (sch_timeout[p] == '0) begin
              sch_ready[p] = 1'b1;
              sch_delayed[p] = 1'b0;
            end
          end
        end
      end
      KIND_DELAY: begin
        if (!sch_running_valid || sch_running == '0 || sch_running > PRIO_W'(NUM_PRIOS) ||
            r.delay_ticks == '0) begin
          err = 1'b1;
        end else begin
          idx = 5'(sch_running - PRIO_W'(1));
          ticks = 32'(r.delay_ticks);
          // clamp to what the timeout counter can hold
          if (33'(ticks) > (33'd1 << TIMEOUT_BITS) - 33'd1) begin
            ticks = 32'((33'd1 << TIMEOUT_BITS) - 33'd1);
          end
          sch_timeout[idx] = TIMEOUT_BITS'(ticks);
          sch_ready[idx] = 1'b0;
          sch_delayed[idx] = 1'b1;
          sw = pick_next_thread();
        end
      end
      KIND_REGISTER: begin
        if (r.thread_prio > PRIO_W'(NUM_PRIOS) || sch_registered[r.thread_prio]) begin
          err = 1'b1;
        end else begin
          sch_registered[r.thread_prio] = 1'b1;
          if (r.thread_prio != '0) begin
            sch_ready[5'(r.thread_prio - PRIO_W'(1))] = 1'b1;
          end
        end
      end
      default: begin
        sw = pick_next_thread();
      end
    endcase
    res.next_prio      = sch_running_valid ? sch_running : '0;
    res.switch_request = sw;
    res.error_flag     = err;
    res.ready_bits     = BITS_W'(sch_ready);
    res.delayed_bits   = BITS_W'(sch_delayed);
    return res;
  endfunction

  // mismatch reporting
  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    n_mismatches++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", n_cycles, what, got, want);
  endtask

  // result checking
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        report("unexpected result transaction", 64'(result_o), '0);
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (result_o.next_prio !== want.next_prio) begin
          report("next_prio", 64'(result_o.next_prio), 64'(want.next_prio));
        end
        if (result_o.switch_request !== want.switch_request) begin
          report("switch_request", 64'(result_o.switch_request), 64'(want.switch_request));
        end
        if (result_o.error_flag !== want.error_flag) begin
          report("error_flag", 64'(result_o.error_flag), 64'(want.error_flag));
        end
        if (result_o.ready_bits !== want.ready_bits) begin
          report("ready_bits", 64'(result_o.ready_bits), 64'(want.ready_bits));
        end
        if (result_o.delayed_bits !== want.delayed_bits) begin
          report("delayed_bits", 64'(result_o.delayed_bits), 64'(want.delayed_bits));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("testbench failed");
      $finish;
    end
  end

  // one transaction on the request channel
  task automatic send_event(input req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    expected_results.push_back(sched_predict(r));
    n_events++;
    if (expected_results[$].error_flag) n_rejected++;
    if (expected_results[$].switch_request) n_switches++;
  endtask

  function automatic req_t make_event(input kind_e k, input int unsigned prio,
                                      input int unsigned ticks);
    req_t r;
    r.kind        = k;
    r.thread_prio = PRIO_W'(prio);
    r.delay_ticks = TICKS_W'(ticks);
    return r;
  endfunction

  // random sender gap, each cycle idle with the given percentage
  task automatic sender_gap(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // mostly legal kernel traffic with random content, some bad requests
  function automatic req_t random_event();
    req_t r;
    int unsigned sel;
    r.thread_prio = PRIO_W'($urandom);
    r.delay_ticks = TICKS_W'($urandom);
    sel = $urandom_range(99);
    if (sel < 35) begin
      r.kind = KIND_TICK;
    end else if (sel < 60) begin
      r.kind = KIND_DELAY;
      // short delays keep threads cycling; a few zero or very long ones
      if (sch_running_valid && sch_running != '0) begin
        sel = $urandom_range(99);
        if (sel < 6) r.delay_ticks = '0;
        else if (sel >= 8) r.delay_ticks = TICKS_W'($urandom_range(1, 12));
      end
    end else if (sel < 75) begin
      r.kind = KIND_REGISTER;
      if ($urandom_range(3) != 0) r.thread_prio = PRIO_W'($urandom_range(0, NUM_PRIOS));
    end else begin
      r.kind = KIND_SCHEDULE;
    end
    return r;
  endfunction

  // first schedule, rejected requests, registration and a delay round trip
  task automatic test_directed_events();
    send_event(make_event(KIND_DELAY, 0, 16'hffff));
    send_event(make_event(KIND_SCHEDULE, 63, 0));
    send_event(make_event(KIND_SCHEDULE, 0, 16'hffff));
    send_event(make_event(KIND_DELAY, 0, 5));
    send_event(make_event(KIND_TICK, 63, 16'hffff));
    send_event(make_event(KIND_REGISTER, 0, 0));
    send_event(make_event(KIND_REGISTER, 0, 0));
    send_event(make_event(KIND_REGISTER, 33, 0));
    send_event(make_event(KIND_REGISTER, 63, 0));
    send_event(make_event(KIND_REGISTER, 32, 0));
    send_event(make_event(KIND_REGISTER, 1, 0));
    send_event(make_event(KIND_REGISTER, 32, 0));
    send_event(make_event(KIND_TICK, 0, 0));
    send_event(make_event(KIND_SCHEDULE, 0, 0));
    send_event(make_event(KIND_DELAY, 0, 0));
    send_event(make_event(KIND_DELAY, 63, 2));
    send_event(make_event(KIND_TICK, 0, 0));
    send_event(make_event(KIND_TICK, 0, 0));
    send_event(make_event(KIND_SCHEDULE, 0, 0));
    send_event(make_event(KIND_DELAY, 0, 1));
    send_event(make_event(KIND_SCHEDULE, 0, 0));
    send_event(make_event(KIND_DELAY, 0, 16'hffff));
    send_event(make_event(KIND_SCHEDULE, 0, 0));
    send_event(make_event(KIND_TICK, 0, 0));
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct);
    repeat (count) begin
      send_event(random_event());
      sender_gap(idle_pct);
    end
  endtask

  // hold the request channel off until every result has come back
  task automatic test_pause_until_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    n_events = 0;
    n_checked = 0;
    n_mismatches = 0;
    n_rejected = 0;
    n_switches = 0;
    n_cycles = 0;
    sch_ready = '0;
    sch_delayed = '0;
    sch_registered = '0;
    for (int p = 0; p < NUM_PRIOS; p++) sch_timeout[p] = '0;
    sch_running = '0;
    sch_running_valid = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_events();
    test_random_traffic(450, 0);
    test_random_traffic(450, 70);
    test_pause_until_drained();
    test_random_traffic(400, 30);
    test_random_traffic(450, 0);

    // drain and let the pipeline settle
    start_i <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    while (expected_results.size() != 0) begin
      report("result never arrived", '0, 64'(expected_results.pop_front()));
    end

    $display("covered %0d kernel events (%0d rejected, %0d switch requests), %0d results checked",
             n_events, n_rejected, n_switches, n_checked);
    $display("ticks, delays, registrations and schedules under back-to-back and gapped traffic");
    if (n_mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
